// File: rtl/bedc_pkg.sv
`timescale 1ns / 1ps

package bedc_pkg;

  // Event codes reported per button.
  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_DOWN   = 3'd1;
  localparam logic [2:0] EV_UP     = 3'd2;
  localparam logic [2:0] EV_HELD   = 3'd3;
  localparam logic [2:0] EV_DOUBLE = 3'd4;

  localparam int unsigned OutButtons = 3;

  localparam logic [15:0] WindowReset = 16'd500;

  typedef struct packed {
    logic [2:0]  button_levels;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [2:0] left_event;
    logic [2:0] right_event;
    logic [2:0] middle_event;
  } out_t;

endpackage

// File: rtl/bedc_button.sv
`timescale 1ns / 1ps

// Edge and click tracking for one button. State moves on when step_i is high.
module bedc_button (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic        level_i,
  input  logic [31:0] now_i,
  input  logic [15:0] window_i,
  output logic [2:0]  event_o
);
  import bedc_pkg::*;

  logic        prev_q, prev_d;
  logic [1:0]  count_q, count_d;
  logic [31:0] first_q, first_d;
  logic [31:0] elapsed;
  logic        past_window;
  logic        within_window;
  logic [1:0]  count_base;

  assign elapsed       = now_i - first_q;
  assign past_window   = elapsed >= {16'd0, window_i};
  assign within_window = elapsed <= {16'd0, window_i};

  always_comb begin
    event_o    = EV_NONE;
    count_d    = count_q;
    first_d    = first_q;
    prev_d     = level_i;
    count_base = count_q;
    case ({prev_q, level_i})
      2'b01: begin
        event_o = EV_DOWN;
        if (count_q == 2'd1 && past_window) begin
          count_base = 2'd0;
        end
        if (count_base < 2'd2) begin
          count_d = count_base + 2'd1;
        end else begin
          count_d = count_base;
        end
        if (count_d == 2'd1) begin
          first_d = now_i;
        end
      end
      2'b10: begin
        event_o = EV_UP;
        if (count_q == 2'd1) begin
          if (past_window) begin
            count_d = 2'd0;
          end
        end else if (count_q == 2'd2) begin
          if (within_window) begin
            event_o = EV_DOUBLE;
          end
          count_d = 2'd0;
        end
      end
      2'b11: event_o = EV_HELD;
      default: event_o = EV_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 1'b0;
      count_q <= 2'd0;
      first_q <= 32'd0;
    end else if (step_i) begin
      prev_q  <= prev_d;
      count_q <= count_d;
      first_q <= first_d;
    end
  end

endmodule

// File: rtl/button_edge_double_click_detector_unit.sv
`timescale 1ns / 1ps
// A poll accepted on the input channel waits in the input register, then moves to the
// result register, which presents it on out_valid_o.
// Throughput: one poll per cycle while out_stall_i is low; the input and result registers
// form a two-stage pipeline, so a new poll is taken while a finished result waits downstream.
// Reset: asynchronous, active low; clears all button history and loads a 500 ms window.

module button_edge_double_click_detector_unit #(
  parameter int unsigned BUTTON_COUNT = 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // Poll input channel.
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bedc_pkg::in_t in_data_i,
  // Event output channel.
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bedc_pkg::out_t out_data_o,
  // Window register write channel.
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [15:0]   cfg_data_i
);
  import bedc_pkg::*;

  // Only the first three buttons have a level input and a result field. Any further
  // buttons always see a released level, so they never change state and are not built.
  localparam int unsigned CellCount = (BUTTON_COUNT < OutButtons) ? BUTTON_COUNT : OutButtons;

  logic        in_valid_q;
  in_t         in_q;
  logic        out_valid_q;
  out_t        out_q;
  logic [15:0] window_q;

  logic        advance;
  logic        in_take;
  logic [2:0]  events [OutButtons];

  // The cfg register is always writable; users must write it only while idle (unchecked).
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WindowReset;
    end else if (cfg_valid_i) begin
      window_q <= cfg_data_i;
    end
  end

  // The poll in the input register moves to the result register whenever the result
  // register is empty or its beat is being taken this cycle. The button state is
  // updated in that same cycle, so each poll sees the history of the one before it.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  // One tracker per existing button; the result field of a missing button reads none.
  for (genvar b = 0; b < OutButtons; b++) begin : g_btn
    if (b < CellCount) begin : g_cell
      bedc_button u_button (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .step_i   (advance),
        .level_i  (in_q.button_levels[b]),
        .now_i    (in_q.now_ms),
        .window_i (window_q),
        .event_o  (events[b])
      );
    end else begin : g_none
      assign events[b] = EV_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.left_event   <= events[0];
      out_q.right_event  <= events[1];
      out_q.middle_event <= events[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the button edge and double-click detector.
//
// Polls are queued by the stimulus process below and presented by a clocked
// driver; every poll accepted by the unit is run through a local model of the
// three button state machines, and the events it predicts are queued until the
// monitor sees the matching result beat. The run goes through several window
// settings, including both ends of the 16-bit range, and through several
// patterns of idle and stall on the two channels.

module tb_top;

  import bedc_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  // Settling time after the last result before the window may be rewritten.
  localparam int unsigned DrainPad   = 4;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Every input of the unit starts from a known value.
  logic        in_valid = 1'b0;
  in_t         in_data = '0;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [15:0] cfg_data = '0;

  logic        in_stall;
  logic        out_valid;
  out_t        out_data;
  logic        cfg_ready;

  // Polls waiting to be presented, and the events predicted for accepted polls.
  in_t  pending_polls[$];
  out_t expected_events[$];

  // Idle and stall likelihoods in percent, changed only between phases.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Local copy of the unit's state: window register and per-button history.
  logic [15:0] window_ms = WindowReset;
  logic        last_level[3] = '{default: 1'b0};
  logic [1:0]  clicks[3] = '{default: 2'd0};
  logic [31:0] first_press_ms[3] = '{default: 32'd0};

  int unsigned errors = 0;
  int unsigned beats_checked = 0;
  int unsigned doubles_seen = 0;
  int unsigned window_writes = 0;
  int unsigned cycle_count = 0;

  button_edge_double_click_detector_unit u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Advances one button by one poll and returns its event. The elapsed time
  // is measured from the first press of the current sequence, modulo 2^32.
  function automatic logic [2:0] step_button(int b, logic level, logic [31:0] now);
    logic [2:0]  ev;
    logic [31:0] elapsed;
    elapsed = now - first_press_ms[b];
    if (!last_level[b] && level) ev = EV_DOWN;
    else if (last_level[b] && !level) ev = EV_UP;
    else if (last_level[b] && level) ev = EV_HELD;
    else ev = EV_NONE;

    if (ev == EV_DOWN) begin
      // A second press after the window has run out starts a fresh sequence.
      if (clicks[b] == 2'd1 && elapsed >= window_ms) clicks[b] = 2'd0;
      if (clicks[b] < 2'd2) clicks[b] = clicks[b] + 2'd1;
      if (clicks[b] == 2'd1) first_press_ms[b] = now;
    end else if (ev == EV_UP) begin
      if (clicks[b] == 2'd1) begin
        if (elapsed >= window_ms) clicks[b] = 2'd0;
      end else if (clicks[b] == 2'd2) begin
        // The bound is inclusive here, unlike the restart test on a press.
        if (elapsed <= window_ms) ev = EV_DOUBLE;
        clicks[b] = 2'd0;
      end
    end
    last_level[b] = level;
    return ev;
  endfunction

  function automatic out_t predict_events(in_t poll);
    out_t res;
    res.left_event   = step_button(0, poll.button_levels[0], poll.now_ms);
    res.right_event  = step_button(1, poll.button_levels[1], poll.now_ms);
    res.middle_event = step_button(2, poll.button_levels[2], poll.now_ms);
    return res;
  endfunction

  // Driver. A beat that is held under stall is left untouched; otherwise the
  // next pending poll is offered unless the sender decides to idle this cycle.
  // The prediction is made at the edge where the poll is accepted, so a
  // window write between phases is seen in the right order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_events.push_back(predict_events(in_data));
        void'(pending_polls.pop_front());
      end
      if (!(in_valid && in_stall)) begin
        if (pending_polls.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_polls[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string field, logic [2:0] want, logic [2:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
    if (got == EV_DOUBLE) doubles_seen++;
  endtask

  // Monitor. Each result beat is matched against the oldest prediction; the
  // stall for the following cycle is drawn afresh at every edge.
  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, expected none, actual %h",
                   $time, out_data);
        end else begin
          want = expected_events.pop_front();
          check_field("left_event", want.left_event, out_data.left_event);
          check_field("right_event", want.right_event, out_data.right_event);
          check_field("middle_event", want.middle_event, out_data.middle_event);
          beats_checked++;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic queue_poll(logic [2:0] levels, logic [31:0] now);
    in_t poll;
    poll.button_levels = levels;
    poll.now_ms        = now;
    pending_polls.push_back(poll);
  endtask

  // Mostly well-formed click traffic: the clock moves forward in steps of up
  // to half the window plus one, so presses and releases land on both sides of it and
  // now and then exactly on it. A few polls are noise with a random level
  // pattern and a random tick, which also exercises every bit of now_ms.
  task automatic queue_random_polls(int unsigned count, logic [15:0] win);
    logic [31:0] tick;
    logic [2:0]  levels;
    int unsigned step_max;
    tick     = $urandom();
    levels   = 3'($urandom_range(7));
    step_max = int'(win) / 2 + 1;
    repeat (count) begin
      if ($urandom_range(99) < 6) begin
        queue_poll(3'($urandom_range(7)), $urandom());
      end else begin
        for (int b = 0; b < 3; b++) begin
          if ($urandom_range(99) < 35) levels[b] = ~levels[b];
        end
        tick = tick + $urandom_range(step_max);
        queue_poll(levels, tick);
      end
    end
  endtask

  // Waits until every queued poll has been taken and every result checked.
  task automatic wait_drained();
    while (pending_polls.size() != 0 || expected_events.size() != 0) @(posedge clk);
    repeat (DrainPad) @(posedge clk);
  endtask

  // Writes the window register; only called while both channels are quiet.
  task automatic write_window(logic [15:0] win);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= win;
    do @(posedge clk); while (!cfg_ready);
    window_ms = win;
    window_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct,
                           logic [15:0] win, int unsigned count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    write_window(win);
    queue_random_polls(count, win);
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed polls against the 500 ms reset window.
    queue_poll(3'b000, 32'd0);            // nothing pressed
    queue_poll(3'b111, 32'd100);          // all down, sequence starts
    queue_poll(3'b111, 32'd150);          // held
    queue_poll(3'b000, 32'd200);          // up inside the window
    queue_poll(3'b111, 32'd300);          // second press
    queue_poll(3'b000, 32'd400);          // double click on all three
    queue_poll(3'b001, 32'd1000);
    queue_poll(3'b000, 32'd1500);         // release exactly at the window: count cleared
    queue_poll(3'b001, 32'd1600);
    queue_poll(3'b000, 32'd1700);
    queue_poll(3'b001, 32'd2100);         // press exactly at the window: restart
    queue_poll(3'b000, 32'd2200);
    queue_poll(3'b001, 32'd2300);
    queue_poll(3'b000, 32'd2600);         // second release exactly at the window: double
    queue_poll(3'b010, 32'd3000);
    queue_poll(3'b000, 32'd3100);
    queue_poll(3'b010, 32'd3200);
    queue_poll(3'b000, 32'd3501);         // one past the window: plain up
    queue_poll(3'b100, 32'hFFFF_FF00);    // sequence across the tick wrap
    queue_poll(3'b000, 32'hFFFF_FFFF);
    queue_poll(3'b100, 32'h0000_0010);
    queue_poll(3'b000, 32'h0000_0050);
    queue_poll(3'b110, 32'h8000_0000);
    queue_poll(3'b101, 32'hFFFF_FFFF);    // down, up and held in one poll
    queue_poll(3'b011, 32'h7FFF_FFFF);
    wait_drained();

    // Random phases over the window range and the idle patterns.
    run_phase(0, 0, 16'd0, 250);
    run_phase(84, 0, 16'hFFFF, 250);
    run_phase(0, 84, 16'd7, 300);
    run_phase(21, 21, WindowReset, 300);
    run_phase(0, 0, 16'd2, 250);
    run_phase(84, 0, 16'($urandom_range(65535)), 250);
    run_phase(21, 21, 16'd40, 250);

    repeat (DrainPad) @(posedge clk);
    $display("Checked %0d result beats under %0d window settings, from 0 to 65535 ms,",
             beats_checked, window_writes + 1);
    $display("with %0d double-click events among them and %0d mismatches.",
             doubles_seen, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/bedc_pkg.sv
rtl/bedc_button.sv
rtl/button_edge_double_click_detector_unit.sv
sim/tb_top.sv
